// ===== design/ppst_pkg.sv =====
package ppst_pkg;

    localparam int MAX_PEERS_DEF = 16;
    localparam int ID_BITS_DEF   = 32;

    localparam logic [2:0] MODE_INITIATE = 3'd0;
    localparam logic [2:0] MODE_REQUEST  = 3'd1;
    localparam logic [2:0] MODE_RESPONSE = 3'd2;
    localparam logic [2:0] MODE_FORCE    = 3'd3;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_CODE    = 3'd1;
    localparam logic [2:0] ERR_ILLEGAL = 3'd2;
    localparam logic [2:0] ERR_UNKNOWN = 3'd3;
    localparam logic [2:0] ERR_FULL    = 3'd4;

    localparam logic [3:0] ST_DISCOVERED = 4'd0;
    localparam logic [3:0] ST_UNTRUSTED  = 4'd1;
    localparam logic [3:0] ST_PAIRING    = 4'd2;
    localparam logic [3:0] ST_TRUSTED    = 4'd3;
    localparam logic [3:0] ST_REJECTED   = 4'd7;
    localparam logic [3:0] ST_LAST       = 4'd8;

    // bit t of row f set: move from f to t is legal
    localparam logic [15:0] LEGAL_MOVES [0:8] = '{
        16'h0083, 16'h0086, 16'h018C, 16'h0118, 16'h0130,
        16'h0160, 16'h0140, 16'h0081, 16'h0103
    };

    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] peer_id;
        logic        code_present;
        logic        accepted;
        logic [3:0]  target_state;
        logic [31:0] fence;
    } req_t;

    typedef struct packed {
        logic [2:0]  error;
        logic [3:0]  peer_state;
        logic        reply_valid;
        logic [31:0] reply_peer_id;
        logic        reply_accepted;
        logic [31:0] reply_fence;
    } rsp_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic       active;
        logic       found;
        logic [3:0] state;
    } probe_t;

    // broadcast entry update
    typedef struct packed {
        logic       en;
        logic       add;
        logic [3:0] state;
    } wr_t;

    function automatic logic move_legal(input logic [3:0] from, input logic [3:0] to);
        logic ok;
        ok = 1'b0;
        if (from <= ST_LAST && to <= ST_LAST)
        begin
            ok = LEGAL_MOVES[from][to];
        end
        return ok;
    endfunction

endpackage

// ===== design/ppst_cell.sv =====
module ppst_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5,
    parameter int KEY_W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CNT_W-1:0]     count,
    input  logic [KEY_W-1:0]     key,
    input  logic                 clear,
    input  ppst_pkg::wr_t        wr,
    input  ppst_pkg::probe_t     probe_in,
    output ppst_pkg::probe_t     probe_out
);

    localparam logic [CNT_W-1:0] IDX_C = CNT_W'(IDX);

    logic [KEY_W-1:0]  key_reg;
    logic [3:0]        state_reg;
    logic              hit_reg;
    logic              hit_next;
    ppst_pkg::probe_t  probe_reg;
    ppst_pkg::probe_t  probe_next;
    logic              match;
    logic              sel;

    assign match = probe_in.active && !probe_in.found && (IDX_C < count) && (key_reg == key);
    assign sel   = wr.add ? (count == IDX_C) : hit_reg;

    always_comb
    begin
        probe_next = probe_in;
        if (match)
        begin
            probe_next.found = 1'b1;
            probe_next.state = state_reg;
        end
        hit_next = clear ? 1'b0 : (match ? 1'b1 : hit_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            probe_reg <= probe_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && sel)
        begin
            state_reg <= wr.state;
            if (wr.add)
            begin
                key_reg <= key;
            end
        end
    end

    assign probe_out = probe_reg;

endmodule

// ===== design/peer_pairing_state_table_core.sv =====
// peer pairing state table
// request channel: start with req; taken at a clock edge where start is high
// and busy is low. busy stays high until the result has been delivered.
// result channel: done is high for exactly one cycle with rsp valid; the
// receiver cannot stall, so every result is taken in that cycle.
// the peers live in a row of MAX_PEERS cells. a search token enters the first
// cell in the cycle after the request is taken and moves one cell per cycle,
// picking up the state of the matching peer. when it leaves the last cell
// the update is written back and the result is registered.
// busy falls with done, so a new request can be taken while done is high;
// no new request is taken while one is still moving through the cell chain.
// reset empties the table (peer count zero) and returns to idle at once;
// no clearing pass is needed.
module peer_pairing_state_table_core #(
    parameter int MAX_PEERS = ppst_pkg::MAX_PEERS_DEF,
    parameter int ID_BITS   = ppst_pkg::ID_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  ppst_pkg::req_t req,
    output logic           done,
    output ppst_pkg::rsp_t rsp
);

    localparam int KEY_W = (ID_BITS < 32) ? ID_BITS : 32;
    localparam int CNT_W = $clog2(MAX_PEERS + 1);
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(MAX_PEERS);

    typedef enum logic [1:0] { S_IDLE, S_SEARCH } fsm_t;

    fsm_t              state_reg;
    ppst_pkg::req_t    req_reg;
    ppst_pkg::rsp_t    rsp_reg;
    ppst_pkg::rsp_t    rsp_next;
    logic              done_reg;
    logic              launch_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              accept;
    logic              finish;
    logic [KEY_W-1:0]  key;
    ppst_pkg::wr_t     wr;
    ppst_pkg::probe_t  chain [0:MAX_PEERS];
    ppst_pkg::probe_t  last;
    logic [3:0]        cur;
    logic [3:0]        from;
    logic              full;

    assign accept = start && (state_reg == S_IDLE);
    assign busy   = (state_reg != S_IDLE);
    assign key    = req_reg.peer_id[KEY_W-1:0];
    assign chain[0] = '{active: launch_reg, found: 1'b0, state: ppst_pkg::ST_DISCOVERED};
    assign last   = chain[MAX_PEERS];
    assign finish = (state_reg == S_SEARCH) && last.active;
    assign full   = (count_reg == FULL_C);
    assign cur    = last.found ? last.state : ppst_pkg::ST_DISCOVERED;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_PEERS; gi++)
        begin : g_cell
            ppst_cell #(
                .IDX   (gi),
                .CNT_W (CNT_W),
                .KEY_W (KEY_W)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .count     (count_reg),
                .key       (key),
                .clear     (accept),
                .wr        (wr),
                .probe_in  (chain[gi]),
                .probe_out (chain[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        wr         = '0;
        from       = (cur == ppst_pkg::ST_DISCOVERED) ? ppst_pkg::ST_UNTRUSTED : cur;
        rsp_next   = '0;
        rsp_next.error      = ppst_pkg::ERR_NONE;
        rsp_next.peer_state = cur;
        case (req_reg.mode)
            ppst_pkg::MODE_INITIATE, ppst_pkg::MODE_REQUEST:
            begin
                if (!req_reg.code_present)
                begin
                    rsp_next.error = ppst_pkg::ERR_CODE;
                end
                else if (!last.found && full)
                begin
                    rsp_next.error = ppst_pkg::ERR_FULL;
                end
                else if (req_reg.mode == ppst_pkg::MODE_REQUEST)
                begin
                    wr = '{en: 1'b1, add: !last.found, state: ppst_pkg::ST_TRUSTED};
                    rsp_next.reply_valid    = 1'b1;
                    rsp_next.reply_peer_id  = 32'(key);
                    rsp_next.reply_accepted = 1'b1;
                    rsp_next.reply_fence    = req_reg.fence;
                end
                else if (ppst_pkg::move_legal(from, ppst_pkg::ST_PAIRING))
                begin
                    wr = '{en: 1'b1, add: !last.found, state: ppst_pkg::ST_PAIRING};
                end
                else
                begin
                    rsp_next.error = ppst_pkg::ERR_ILLEGAL;
                end
            end
            ppst_pkg::MODE_RESPONSE:
            begin
                if (!last.found)
                begin
                    rsp_next.error = ppst_pkg::ERR_UNKNOWN;
                end
                else if (!req_reg.accepted)
                begin
                    wr = '{en: 1'b1, add: 1'b0, state: ppst_pkg::ST_REJECTED};
                end
                else if (ppst_pkg::move_legal(cur, ppst_pkg::ST_TRUSTED))
                begin
                    wr = '{en: 1'b1, add: 1'b0, state: ppst_pkg::ST_TRUSTED};
                end
                else
                begin
                    rsp_next.error = ppst_pkg::ERR_ILLEGAL;
                end
            end
            ppst_pkg::MODE_FORCE:
            begin
                if (!last.found)
                begin
                    rsp_next.error = ppst_pkg::ERR_UNKNOWN;
                end
                else if (ppst_pkg::move_legal(cur, req_reg.target_state))
                begin
                    wr = '{en: 1'b1, add: 1'b0, state: req_reg.target_state};
                end
                else
                begin
                    rsp_next.error = ppst_pkg::ERR_ILLEGAL;
                end
            end
            default:
            begin
                rsp_next.error = ppst_pkg::ERR_NONE;
            end
        endcase
        if (wr.en)
        begin
            rsp_next.peer_state = wr.state;
        end
        wr.en      = wr.en && finish;
        count_next = (wr.en && wr.add) ? count_reg + 1'b1 : count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            rsp_reg    <= '0;
            launch_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            done_reg   <= 1'b0;
            launch_reg <= accept;
            count_reg  <= count_next;
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (finish)
                    begin
                        state_reg <= S_IDLE;
                        done_reg  <= 1'b1;
                        rsp_reg   <= rsp_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req;
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_C)
        else $error("peer count beyond table size");

    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy && $past(busy))
        else $error("result without a request in flight");

    a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.reply_valid |-> rsp.error == ppst_pkg::ERR_NONE
            && rsp.peer_state == ppst_pkg::ST_TRUSTED)
        else $error("reply on a failed request");

    a_add_only_new: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en && wr.add |-> !last.found && !full)
        else $error("entry added for a known peer or into a full table");
`endif

endmodule

// ===== tb/peer_pairing_state_table_core_test.sv =====
module peer_pairing_state_table_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] MODE_QUERY  = 3'd4;
    localparam logic [2:0] MODE_SPARE0 = 3'd5;
    localparam logic [2:0] MODE_SPARE1 = 3'd6;
    localparam logic [2:0] MODE_SPARE2 = 3'd7;

    localparam logic [3:0] ST_REGISTERING = 4'd4;
    localparam logic [3:0] ST_REGISTERED  = 4'd5;
    localparam logic [3:0] ST_MEMBER      = 4'd6;
    localparam logic [3:0] ST_ROLLBACK    = 4'd8;
    localparam logic [3:0] TARGET_BAD_LO  = 4'd9;
    localparam logic [3:0] TARGET_BAD_HI  = 4'd15;

    // bit t of row f set: move from f to t allowed
    localparam logic [8:0] MOVE_OK [0:8] = '{
        9'h083, 9'h086, 9'h18C, 9'h118, 9'h130, 9'h160, 9'h140, 9'h081, 9'h103
    };

    localparam int REQ_TARGET   = 1550;
    localparam int QUIET_LIMIT  = 4000;
    localparam int SETTLE_CYCLES = ppst_pkg::MAX_PEERS_DEF + 6;

    typedef struct {
        ppst_pkg::req_t item;
        int unsigned    gap;
        bit             drain;
    } pending_req_t;

    logic           clk;
    logic           rst_n;
    logic           start;
    logic           busy;
    ppst_pkg::req_t req;
    logic           done;
    ppst_pkg::rsp_t rsp;

    peer_pairing_state_table_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    pending_req_t   req_q[$];
    ppst_pkg::rsp_t peer_rsp_q[$];

    logic [31:0] model_ids [ppst_pkg::MAX_PEERS_DEF];
    logic [3:0]  model_states [ppst_pkg::MAX_PEERS_DEF];
    int          model_count = 0;

    logic [31:0] pool_ids [16];
    bit          seen_ids [bit [31:0]];
    bit          idle_on = 1'b0;
    int          req_total = 0;

    bit             taken = 1'b0;
    int unsigned    gap_left = 0;
    bit             gap_used = 1'b0;
    int             quiet_cycles = 0;
    int             fail_count = 0;
    ppst_pkg::rsp_t want;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit move_allowed(input logic [3:0] from, input logic [3:0] to);
        if (from > ppst_pkg::ST_LAST || to > ppst_pkg::ST_LAST)
        begin
            return 1'b0;
        end
        return MOVE_OK[from][to];
    endfunction

    function automatic int peer_index(input logic [31:0] id);
        for (int i = 0; i < model_count; i++)
        begin
            if (model_ids[i] == id)
            begin
                return i;
            end
        end
        return -1;
    endfunction

    function automatic int peer_index_or_add(input logic [31:0] id, input logic [3:0] first);
        int k;
        k = peer_index(id);
        if (k < 0 && model_count < ppst_pkg::MAX_PEERS_DEF)
        begin
            k = model_count;
            model_ids[k] = id;
            model_states[k] = first;
            model_count++;
        end
        return k;
    endfunction

    function automatic ppst_pkg::rsp_t pairing_predict(input ppst_pkg::req_t r);
        ppst_pkg::rsp_t o;
        int             k;
        logic [2:0]     err;
        logic           reply;
        o = '0;
        err = ppst_pkg::ERR_NONE;
        reply = 1'b0;
        case (r.mode)
            ppst_pkg::MODE_INITIATE:
            begin
                if (!r.code_present)
                begin
                    err = ppst_pkg::ERR_CODE;
                end
                else
                begin
                    k = peer_index_or_add(r.peer_id, ppst_pkg::ST_DISCOVERED);
                    if (k < 0)
                    begin
                        err = ppst_pkg::ERR_FULL;
                    end
                    else
                    begin
                        if (model_states[k] == ppst_pkg::ST_DISCOVERED)
                        begin
                            model_states[k] = ppst_pkg::ST_UNTRUSTED;
                        end
                        if (!move_allowed(model_states[k], ppst_pkg::ST_PAIRING))
                        begin
                            err = ppst_pkg::ERR_ILLEGAL;
                        end
                        else
                        begin
                            model_states[k] = ppst_pkg::ST_PAIRING;
                        end
                    end
                end
            end
            ppst_pkg::MODE_REQUEST:
            begin
                if (!r.code_present)
                begin
                    err = ppst_pkg::ERR_CODE;
                end
                else
                begin
                    k = peer_index_or_add(r.peer_id, ppst_pkg::ST_UNTRUSTED);
                    if (k < 0)
                    begin
                        err = ppst_pkg::ERR_FULL;
                    end
                    else
                    begin
                        model_states[k] = ppst_pkg::ST_TRUSTED;
                        reply = 1'b1;
                    end
                end
            end
            ppst_pkg::MODE_RESPONSE:
            begin
                k = peer_index(r.peer_id);
                if (k < 0)
                begin
                    err = ppst_pkg::ERR_UNKNOWN;
                end
                else if (!r.accepted)
                begin
                    model_states[k] = ppst_pkg::ST_REJECTED;
                end
                else if (!move_allowed(model_states[k], ppst_pkg::ST_TRUSTED))
                begin
                    err = ppst_pkg::ERR_ILLEGAL;
                end
                else
                begin
                    model_states[k] = ppst_pkg::ST_TRUSTED;
                end
            end
            ppst_pkg::MODE_FORCE:
            begin
                k = peer_index(r.peer_id);
                if (k < 0)
                begin
                    err = ppst_pkg::ERR_UNKNOWN;
                end
                else if (!move_allowed(model_states[k], r.target_state))
                begin
                    err = ppst_pkg::ERR_ILLEGAL;
                end
                else
                begin
                    model_states[k] = r.target_state;
                end
            end
            default:
            begin
            end
        endcase
        k = peer_index(r.peer_id);
        o.error = err;
        o.peer_state = (k >= 0) ? model_states[k] : ppst_pkg::ST_DISCOVERED;
        o.reply_valid = reply;
        o.reply_peer_id = reply ? r.peer_id : 32'd0;
        o.reply_accepted = reply;
        o.reply_fence = reply ? r.fence : 32'd0;
        return o;
    endfunction

    task automatic check_field(input string fname, input logic [31:0] exp_val,
                               input logic [31:0] act_val);
        if (act_val !== exp_val)
        begin
            $display("%0t mismatch %s: expected %h actual %h", $time, fname, exp_val, act_val);
            fail_count++;
        end
    endtask

    task automatic add_req(input logic [2:0] mode, input logic [31:0] id, input bit code,
                           input bit acc, input logic [3:0] target, input logic [31:0] fence,
                           input bit drain);
        pending_req_t p;
        p.item.mode = mode;
        p.item.peer_id = id;
        p.item.code_present = code;
        p.item.accepted = acc;
        p.item.target_state = target;
        p.item.fence = fence;
        p.gap = idle_on ? $urandom_range(0, 12) : 0;
        p.drain = drain;
        if ((mode == ppst_pkg::MODE_INITIATE || mode == ppst_pkg::MODE_REQUEST) && code
            && !seen_ids.exists(id) && seen_ids.num() < ppst_pkg::MAX_PEERS_DEF)
        begin
            seen_ids[id] = 1'b1;
        end
        req_q.insert(req_q.size(), p);
        req_total++;
    endtask

    task automatic add_pairing_flow();
        logic [31:0] id;
        int          len;
        id = pool_ids[4'($urandom_range(0, 15))];
        len = $urandom_range(1, 7);
        for (int s = 0; s < len; s++)
        begin
            case (s)
                0: add_req($urandom_range(0, 1) ? ppst_pkg::MODE_INITIATE
                                                : ppst_pkg::MODE_REQUEST, id,
                           $urandom_range(0, 15) != 0, 1'($urandom_range(0, 1)),
                           4'($urandom), $urandom, 1'b0);
                1: add_req(ppst_pkg::MODE_RESPONSE, id, 1'($urandom_range(0, 1)),
                           $urandom_range(0, 9) != 0, 4'($urandom), $urandom, 1'b0);
                2: add_req(ppst_pkg::MODE_FORCE, id, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), ST_REGISTERING, $urandom, 1'b0);
                3: add_req(ppst_pkg::MODE_FORCE, id, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), ST_REGISTERED, $urandom, 1'b0);
                4: add_req(ppst_pkg::MODE_FORCE, id, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), ST_MEMBER, $urandom, 1'b0);
                5: add_req(ppst_pkg::MODE_FORCE, id, 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1)), ST_ROLLBACK, $urandom, 1'b0);
                default: add_req(ppst_pkg::MODE_FORCE, id, 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 1) ? ppst_pkg::ST_DISCOVERED
                                                      : ppst_pkg::ST_UNTRUSTED,
                                 $urandom, 1'b0);
            endcase
        end
    endtask

    task automatic add_random_req();
        logic [2:0]  mode;
        logic [31:0] id;
        logic [3:0]  target;
        bit          code;
        mode = 3'($urandom_range(0, 7));
        code = $urandom_range(0, 7) != 0;
        target = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 8)) : 4'($urandom);
        id = pool_ids[4'($urandom_range(0, 15))];
        if ($urandom_range(0, 99) < 15)
        begin
            // new peers only once the pool has filled the table
            if (!((mode == ppst_pkg::MODE_INITIATE || mode == ppst_pkg::MODE_REQUEST) && code
                  && seen_ids.num() < ppst_pkg::MAX_PEERS_DEF))
            begin
                id = $urandom;
            end
        end
        add_req(mode, id, code, 1'($urandom_range(0, 1)), target, $urandom,
                $urandom_range(0, 99) == 0);
    endtask

    always @(negedge clk)
    begin
        if (rst_n && (!start || taken))
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (req_q.size() != 0)
            begin
                if (!gap_used && req_q[0].gap != 0)
                begin
                    gap_left = req_q[0].gap - 1;
                    gap_used = 1'b1;
                    start <= 1'b0;
                end
                else if (req_q[0].drain && peer_rsp_q.size() != 0)
                begin
                    start <= 1'b0;
                end
                else
                begin
                    req <= req_q[0].item;
                    void'(req_q.pop_front());
                    gap_used = 1'b0;
                    start <= 1'b1;
                end
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (peer_rsp_q.size() == 0)
                begin
                    $display("%0t mismatch unexpected result: expected none actual %h",
                             $time, rsp);
                    fail_count++;
                end
                else
                begin
                    want = peer_rsp_q.pop_front();
                    check_field("error", 32'(want.error), 32'(rsp.error));
                    check_field("peer_state", 32'(want.peer_state), 32'(rsp.peer_state));
                    check_field("reply_valid", 32'(want.reply_valid), 32'(rsp.reply_valid));
                    check_field("reply_peer_id", want.reply_peer_id, rsp.reply_peer_id);
                    check_field("reply_accepted", 32'(want.reply_accepted),
                                32'(rsp.reply_accepted));
                    check_field("reply_fence", want.reply_fence, rsp.reply_fence);
                end
            end
            if (start && !busy)
            begin
                peer_rsp_q.insert(peer_rsp_q.size(), pairing_predict(req));
            end
            if (done || (start && !busy))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("peer_pairing_state_table_core regression: fail");
                $finish;
            end
            taken <= start && !busy;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;

        pool_ids[0] = 32'h0000_0000;
        pool_ids[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++)
        begin
            pool_ids[i] = {4'(i - 1), 28'($urandom)};
        end

        // directed: absent peer, missing code, full pairing walk, bad targets
        add_req(MODE_QUERY, pool_ids[0], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED, 32'h0, 1'b0);
        add_req(ppst_pkg::MODE_RESPONSE, pool_ids[0], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[1], 1'b1, 1'b0, ppst_pkg::ST_UNTRUSTED,
                32'hFFFF_FFFF, 1'b0);
        add_req(ppst_pkg::MODE_INITIATE, pool_ids[0], 1'b0, 1'b0, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_REQUEST, pool_ids[1], 1'b0, 1'b1, TARGET_BAD_HI,
                32'hFFFF_FFFF, 1'b0);
        add_req(ppst_pkg::MODE_INITIATE, pool_ids[0], 1'b1, 1'b0, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_INITIATE, pool_ids[0], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_RESPONSE, pool_ids[0], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[0], 1'b1, 1'b1, ST_REGISTERING, 32'h0, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[0], 1'b1, 1'b1, ST_REGISTERED, 32'h0, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[0], 1'b1, 1'b1, ST_MEMBER, 32'h0, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[0], 1'b1, 1'b1, TARGET_BAD_LO, 32'h0, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[0], 1'b1, 1'b1, TARGET_BAD_HI, 32'h0, 1'b0);
        add_req(ppst_pkg::MODE_INITIATE, pool_ids[0], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_RESPONSE, pool_ids[0], 1'b1, 1'b0, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_RESPONSE, pool_ids[0], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_REQUEST, pool_ids[1], 1'b1, 1'b0, ppst_pkg::ST_DISCOVERED,
                32'hFFFF_FFFF, 1'b0);
        add_req(MODE_SPARE0, pool_ids[1], 1'b0, 1'b0, ppst_pkg::ST_LAST, 32'hFFFF_FFFF, 1'b0);
        add_req(MODE_SPARE1, pool_ids[1], 1'b1, 1'b1, ppst_pkg::ST_LAST, 32'hA5A5_5A5A, 1'b0);
        add_req(MODE_SPARE2, pool_ids[1], 1'b1, 1'b0, TARGET_BAD_HI, 32'h5A5A_A5A5, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[1], 1'b1, 1'b1, ST_ROLLBACK, 32'h0, 1'b0);
        add_req(ppst_pkg::MODE_FORCE, pool_ids[1], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(ppst_pkg::MODE_INITIATE, pool_ids[1], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED,
                32'h0, 1'b0);
        add_req(MODE_QUERY, pool_ids[1], 1'b1, 1'b1, ppst_pkg::ST_DISCOVERED, 32'h0, 1'b1);

        while (req_total < REQ_TARGET)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                idle_on = 1'($urandom_range(0, 1));
            end
            if ($urandom_range(0, 99) < 45)
            begin
                add_pairing_flow();
            end
            else
            begin
                add_random_req();
            end
        end

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        do
        begin
            @(posedge clk);
        end
        while (req_q.size() != 0 || start || peer_rsp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("peer_pairing_state_table_core regression: pass");
        end
        else
        begin
            $display("peer_pairing_state_table_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/ppst_pkg.sv
design/ppst_cell.sv
design/peer_pairing_state_table_core.sv
tb/peer_pairing_state_table_core_test.sv
